FILE: rtl/wst_pkg.sv
// ----------------------------------------------------------------------------
// wst_pkg
// Shared constants, request codes and controller/datapath interface types
// for the windowed saturating tally.
// ----------------------------------------------------------------------------
package wst_pkg;

  // Default configuration
  localparam int DefWindow     = 16;
  localparam int DefCategories = 8;

  // Field widths
  localparam int ReqW   = 2;
  localparam int TickW  = 64;
  localparam int CatW   = 3;
  localparam int AmtW   = 64;
  localparam int TotalW = 64;

  // Stream word widths (payload padded to whole bytes)
  localparam int InDataW  = 136;  // tick, category, amount = 131 bits
  localparam int OutDataW = 128;  // window_total, current_tick

  // Request codes
  localparam logic [ReqW-1:0] ReqAdvance = 2'd0;
  localparam logic [ReqW-1:0] ReqRecord  = 2'd1;
  localparam logic [ReqW-1:0] ReqQuery   = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_req;   // capture the incoming word
    logic tot_clr;    // clear the query accumulator
    logic adv_first;  // first advance: start, take tick, begin modulo
    logic adv_jump;   // backward or far jump: drop all buckets, begin modulo
    logic adv_gap;    // short forward move: take tick, load step count
    logic mod_step;   // four tick bits of tick modulo window
    logic mod_fin;    // commit slot from modulo, clear that bucket
    logic clr_step;   // move slot by one and clear that bucket
    logic start0;     // implicit start at tick zero
    logic rec_rd;     // read active bucket row
    logic rec_wr;     // write back updated bucket row
    logic qry_init;   // reset query sweep
    logic qry_step;   // one bucket of the query sweep
    logic out_load;   // load the result register
  } wst_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [ReqW-1:0] req_type;
    logic            started;
    logic            same_tick;
    logic            in_window;
    logic            cat_ok;
    logic            mod_last;
    logic            steps_last;
    logic            qry_done;
    logic            out_free;
  } wst_stat_t;

endpackage

FILE: rtl/wst_ram.sv
// ----------------------------------------------------------------------------
// wst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wst_ram #(
  parameter int Width = 64,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/wst_dp.sv
// ----------------------------------------------------------------------------
// wst_dp
// Datapath: request register, active tick and slot, bucket row store with
// per-row valid bits, modulo unit, query accumulator and result register.
// ----------------------------------------------------------------------------
module wst_dp #(
  parameter int Window     = wst_pkg::DefWindow,
  parameter int Categories = wst_pkg::DefCategories
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wst_pkg::wst_cmd_t             cmd_i,
  output wst_pkg::wst_stat_t            stat_o,
  input  logic [wst_pkg::ReqW-1:0]      req_type_i,
  input  logic [wst_pkg::TickW-1:0]     tick_i,
  input  logic [wst_pkg::CatW-1:0]      category_i,
  input  logic [wst_pkg::AmtW-1:0]      amount_i,
  input  logic                          m_tready_i,
  output logic                          m_tvalid_o,
  output logic [wst_pkg::TotalW-1:0]    window_total_o,
  output logic [wst_pkg::TickW-1:0]     current_tick_o,
  output logic                          started_o
);

  localparam int SlotW = $clog2(Window);
  // only categories reachable by the 3-bit field are stored
  localparam int MaxCat   = 1 << wst_pkg::CatW;
  localparam int Cols     = (Categories < MaxCat) ? Categories : MaxCat;
  localparam int RowW     = Cols * wst_pkg::TotalW;
  localparam int ModBits  = 4;
  localparam int ModSteps = wst_pkg::TickW / ModBits;
  localparam int CntW     = $clog2(ModSteps);

  localparam logic [SlotW-1:0] LastSlot = SlotW'(Window - 1);
  localparam logic [SlotW:0]   WinWide  = (SlotW + 1)'(Window);
  localparam logic [CntW-1:0]  LastMod  = CntW'(ModSteps - 1);

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  // Request register
  logic [wst_pkg::ReqW-1:0]  req_q;
  logic [wst_pkg::TickW-1:0] tick_q;
  logic [wst_pkg::CatW-1:0]  cat_q;
  logic [wst_pkg::AmtW-1:0]  amt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q  <= req_type_i;
      tick_q <= tick_i;
      cat_q  <= category_i;
      amt_q  <= amount_i;
    end
  end

  // Tick state
  logic [wst_pkg::TickW-1:0] active_d, active_q;
  logic                      started_d, started_q;
  logic [SlotW-1:0]          slot_d, slot_q;
  logic [Window-1:0]         valid_d, valid_q;
  logic [SlotW-1:0]          steps_d, steps_q;
  logic [SlotW-1:0]          slot_inc;

  // Modulo unit: restoring reduction, four tick bits per cycle
  logic [wst_pkg::TickW-1:0] msh_d, msh_q;
  logic [SlotW-1:0]          mr_d, mr_q;
  logic [CntW-1:0]           mcnt_d, mcnt_q;
  logic [SlotW:0]            mr_shift;
  logic [SlotW-1:0]          mr_next;

  // Query sweep
  logic [SlotW:0]             qcnt_d, qcnt_q;
  logic                       pend_d, pend_q;
  logic                       pvld_d, pvld_q;
  logic [wst_pkg::TotalW-1:0] total_d, total_q;

  // Result register
  logic                       ovld_d, ovld_q;
  logic [wst_pkg::TotalW-1:0] otot_q;
  logic [wst_pkg::TickW-1:0]  otick_q;
  logic                       ostart_q;

  // Bucket row store
  logic             ram_we;
  logic [SlotW-1:0] ram_raddr;
  logic [RowW-1:0]  ram_rdata;
  logic [RowW-1:0]  row_new;
  logic [RowW-1:0]  row_base;
  logic [63:0]      rd_field;

  wst_ram #(
    .Width (RowW),
    .Depth (Window)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (row_new),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ram_we    = cmd_i.rec_wr;
  assign ram_raddr = cmd_i.rec_rd ? slot_q : qcnt_q[SlotW-1:0];
  assign slot_inc  = (slot_q == LastSlot) ? '0 : slot_q + 1'b1;
  assign row_base  = valid_q[slot_q] ? ram_rdata : '0;

  // Four shift-and-subtract steps of the tick modulo window
  always_comb begin
    mr_next  = mr_q;
    mr_shift = '0;
    for (int b = 0; b < ModBits; b++) begin
      mr_shift = {mr_next, msh_q[wst_pkg::TickW-1-b]};
      mr_next  = (mr_shift >= WinWide) ? SlotW'(mr_shift - WinWide) : mr_shift[SlotW-1:0];
    end
  end

  // Column select and row update
  always_comb begin
    rd_field = '0;
    row_new  = row_base;
    for (int c = 0; c < Cols; c++) begin
      if (32'(cat_q) == c) begin
        rd_field = ram_rdata[c*64 +: 64];
        row_new[c*64 +: 64] = sat_add(row_base[c*64 +: 64], amt_q);
      end
    end
  end

  // Next-state logic
  always_comb begin
    active_d  = active_q;
    started_d = started_q;
    slot_d    = slot_q;
    valid_d   = valid_q;
    steps_d   = steps_q;
    msh_d     = msh_q;
    mr_d      = mr_q;
    mcnt_d    = mcnt_q;
    qcnt_d    = qcnt_q;
    pend_d    = pend_q;
    pvld_d    = pvld_q;
    total_d   = total_q;
    ovld_d    = ovld_q;

    if (cmd_i.tot_clr) total_d = '0;

    // advance paths
    if (cmd_i.adv_first || cmd_i.adv_jump) begin
      started_d = 1'b1;
      active_d  = tick_q;
      msh_d     = tick_q;
      mr_d      = '0;
      mcnt_d    = '0;
      if (cmd_i.adv_jump) valid_d = '0;
    end
    if (cmd_i.adv_gap) begin
      active_d = tick_q;
      steps_d  = SlotW'(tick_q - active_q);
    end
    if (cmd_i.mod_step) begin
      mr_d   = mr_next;
      msh_d  = {msh_q[wst_pkg::TickW-ModBits-1:0], {ModBits{1'b0}}};
      mcnt_d = mcnt_q + 1'b1;
    end
    if (cmd_i.mod_fin) begin
      slot_d         = mr_q;
      valid_d[mr_q]  = 1'b0;
    end
    if (cmd_i.clr_step) begin
      slot_d            = slot_inc;
      valid_d[slot_inc] = 1'b0;
      steps_d           = steps_q - 1'b1;
    end
    if (cmd_i.start0) begin
      started_d  = 1'b1;
      active_d   = '0;
      slot_d     = '0;
      valid_d[0] = 1'b0;
    end

    // record write-back
    if (cmd_i.rec_wr) valid_d[slot_q] = 1'b1;

    // query sweep: issue one read, accumulate the previous one
    if (cmd_i.qry_init) begin
      qcnt_d = '0;
      pend_d = 1'b0;
    end
    if (cmd_i.qry_step) begin
      if (qcnt_q != WinWide) begin
        pend_d = 1'b1;
        pvld_d = valid_q[qcnt_q[SlotW-1:0]];
        qcnt_d = qcnt_q + 1'b1;
      end else begin
        pend_d = 1'b0;
      end
      if (pend_q && pvld_q) total_d = sat_add(total_q, rd_field);
    end

    // result handshake
    if (ovld_q && m_tready_i) ovld_d = 1'b0;
    if (cmd_i.out_load) ovld_d = 1'b1;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= '0;
      started_q <= 1'b0;
      slot_q    <= '0;
      valid_q   <= '0;
      steps_q   <= '0;
      mcnt_q    <= '0;
      qcnt_q    <= '0;
      pend_q    <= 1'b0;
      ovld_q    <= 1'b0;
    end else begin
      active_q  <= active_d;
      started_q <= started_d;
      slot_q    <= slot_d;
      valid_q   <= valid_d;
      steps_q   <= steps_d;
      mcnt_q    <= mcnt_d;
      qcnt_q    <= qcnt_d;
      pend_q    <= pend_d;
      ovld_q    <= ovld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    msh_q   <= msh_d;
    mr_q    <= mr_d;
    pvld_q  <= pvld_d;
    total_q <= total_d;
    if (cmd_i.out_load) begin
      otot_q   <= total_q;
      otick_q  <= active_q;
      ostart_q <= started_q;
    end
  end

  // Status
  logic [wst_pkg::TickW-1:0] gap;
  assign gap = tick_q - active_q;

  assign stat_o.req_type   = req_q;
  assign stat_o.started    = started_q;
  assign stat_o.same_tick  = (tick_q == active_q);
  assign stat_o.in_window  = (tick_q > active_q) && (gap < 64'(Window));
  assign stat_o.cat_ok     = (32'(cat_q) < Cols);
  assign stat_o.mod_last   = (mcnt_q == LastMod);
  assign stat_o.steps_last = (steps_q == SlotW'(1));
  assign stat_o.qry_done   = (qcnt_q == WinWide) && !pend_q;
  assign stat_o.out_free   = !ovld_q || m_tready_i;

  assign m_tvalid_o     = ovld_q;
  assign window_total_o = otot_q;
  assign current_tick_o = otick_q;
  assign started_o      = ostart_q;

endmodule

FILE: rtl/wst_ctrl.sv
// ----------------------------------------------------------------------------
// wst_ctrl
// Controller: accepts a request word, sequences the datapath through the
// advance, record or query steps and hands the result to the output register.
// ----------------------------------------------------------------------------
module wst_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  wst_pkg::wst_stat_t stat_i,
  output wst_pkg::wst_cmd_t  cmd_o
);

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StDec    = 4'd1;
  localparam logic [3:0] StMod    = 4'd2;
  localparam logic [3:0] StModFin = 4'd3;
  localparam logic [3:0] StClr    = 4'd4;
  localparam logic [3:0] StRecRd  = 4'd5;
  localparam logic [3:0] StRecWr  = 4'd6;
  localparam logic [3:0] StQry    = 4'd7;
  localparam logic [3:0] StDone   = 4'd8;

  logic [3:0] state_d, state_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;

    case (state_q)
      StIdle: begin
        if (s_tvalid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = StDec;
        end
      end

      // pick the sequence for the captured request
      StDec: begin
        cmd_o.tot_clr = 1'b1;
        state_d       = StDone;
        case (stat_i.req_type)
          wst_pkg::ReqAdvance: begin
            if (!stat_i.started) begin
              cmd_o.adv_first = 1'b1;
              state_d         = StMod;
            end else if (stat_i.same_tick) begin
              state_d = StDone;
            end else if (stat_i.in_window) begin
              cmd_o.adv_gap = 1'b1;
              state_d       = StClr;
            end else begin
              cmd_o.adv_jump = 1'b1;
              state_d        = StMod;
            end
          end
          wst_pkg::ReqRecord: begin
            cmd_o.start0 = !stat_i.started;
            if (stat_i.cat_ok) state_d = StRecRd;
          end
          wst_pkg::ReqQuery: begin
            if (stat_i.cat_ok) begin
              cmd_o.qry_init = 1'b1;
              state_d        = StQry;
            end
          end
          default: state_d = StDone;
        endcase
      end

      StMod: begin
        cmd_o.mod_step = 1'b1;
        if (stat_i.mod_last) state_d = StModFin;
      end

      StModFin: begin
        cmd_o.mod_fin = 1'b1;
        state_d       = StDone;
      end

      StClr: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.steps_last) state_d = StDone;
      end

      StRecRd: begin
        cmd_o.rec_rd = 1'b1;
        state_d      = StRecWr;
      end

      StRecWr: begin
        cmd_o.rec_wr = 1'b1;
        state_d      = StDone;
      end

      StQry: begin
        if (stat_i.qry_done) begin
          state_d = StDone;
        end else begin
          cmd_o.qry_step = 1'b1;
        end
      end

      // wait for room in the result register
      StDone: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_tready_o = (state_q == StIdle);

endmodule

FILE: rtl/windowed_saturating_tally.sv
// ----------------------------------------------------------------------------
// windowed_saturating_tally
// Per-category sliding-window tally kept in a ring of tick buckets.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis channel, one word per request; tuser holds
//   the request kind (advance, record, query). Each request yields exactly one
//   result word on the m_axis channel: window total, active tick, started.
//   Work per request, from accept to result loaded:
//     advance to the same tick            no bucket work
//     advance by k ticks inside window    clear the k passed buckets
//     first advance, backward or far jump tick modulo window, 4 bits a cycle
//     record                              read-modify-write of one row
//     query                               all bucket rows, one row a cycle
//   One request is worked on at a time; the next word is accepted as soon as
//   the previous result sits in the output register, even if it is stalled.
//   A stalled receiver holds the result word; a further request completes up
//   to the point of loading and then waits for the register to empty.
//   Reset clears all buckets at once through per-row valid bits; no sweep.
// ----------------------------------------------------------------------------
module windowed_saturating_tally #(
  parameter int Window     = wst_pkg::DefWindow,
  parameter int Categories = wst_pkg::DefCategories
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // slave side
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata: tick[63:0], category[66:64], amount[130:67], zero pad
  input  logic [wst_pkg::InDataW-1:0]    s_axis_tdata_i,
  // tuser: req_type[1:0]
  input  logic [wst_pkg::ReqW-1:0]       s_axis_tuser_i,
  // master side
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // tdata: window_total[63:0], current_tick[127:64]
  output logic [wst_pkg::OutDataW-1:0]   m_axis_tdata_o,
  // tuser: started[0]
  output logic                           m_axis_tuser_o
);

  wst_pkg::wst_cmd_t  cmd;
  wst_pkg::wst_stat_t stat;

  logic [wst_pkg::TotalW-1:0] window_total;
  logic [wst_pkg::TickW-1:0]  current_tick;

  wst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  wst_dp #(
    .Window     (Window),
    .Categories (Categories)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .req_type_i     (s_axis_tuser_i),
    .tick_i         (s_axis_tdata_i[63:0]),
    .category_i     (s_axis_tdata_i[66:64]),
    .amount_i       (s_axis_tdata_i[130:67]),
    .m_tready_i     (m_axis_tready_i),
    .m_tvalid_o     (m_axis_tvalid_o),
    .window_total_o (window_total),
    .current_tick_o (current_tick),
    .started_o      (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {current_tick, window_total};

endmodule

FILE: sim/wst_checker.sv
// ----------------------------------------------------------------------------
// wst_checker
// Watches both stream channels of the windowed saturating tally. It keeps its
// own ring of tick buckets and predicts each result word, then compares the
// words the block sends with the predictions, oldest first.
// ----------------------------------------------------------------------------
module wst_checker
  import wst_pkg::*;
#(
  parameter int Window     = DefWindow,
  parameter int Categories = DefCategories
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // slave side
  input  logic                s_axis_tvalid_i,
  input  logic                s_axis_tready_i,
  // tdata: tick[63:0], category[66:64], amount[130:67], zero pad
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // tuser: req_type[1:0]
  input  logic [ReqW-1:0]     s_axis_tuser_i,
  // master side
  input  logic                m_axis_tvalid_i,
  input  logic                m_axis_tready_i,
  // tdata: window_total[63:0], current_tick[127:64]
  input  logic [OutDataW-1:0] m_axis_tdata_i,
  // tuser: started[0]
  input  logic                m_axis_tuser_i,
  output int                  fail_cnt_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxReports = 10;

  typedef struct packed {
    logic [TotalW-1:0] total;
    logic [TickW-1:0]  tick;
    logic              started;
  } tally_reply_t;

  // Predicted block state
  logic [TotalW-1:0] bucket_sums [Window][Categories];
  logic [TickW-1:0]  live_tick;
  logic              live_started;

  tally_reply_t tally_results_q [$];
  int           mismatch_cnt = 0;

  assign fail_cnt_o = mismatch_cnt;

  function automatic logic [TotalW-1:0] sat_sum(input logic [TotalW-1:0] a,
                                                input logic [TotalW-1:0] b);
    logic [TotalW:0] wide;
    wide = {1'b0, a} + {1'b0, b};
    return wide[TotalW] ? {TotalW{1'b1}} : wide[TotalW-1:0];
  endfunction

  function automatic void clear_slot(input logic [TickW-1:0] t);
    int slot;
    slot = int'(t % TickW'(Window));
    for (int c = 0; c < Categories; c++) bucket_sums[slot][c] = '0;
  endfunction

  function automatic void drop_all_buckets();
    for (int s = 0; s < Window; s++) begin
      for (int c = 0; c < Categories; c++) bucket_sums[s][c] = '0;
    end
  endfunction

  // Move the active tick; clears passed buckets, or all on a backward/far move
  function automatic void move_to(input logic [TickW-1:0] t);
    logic [TickW-1:0] gap;
    gap = t - live_tick;
    if (!live_started) begin
      live_started = 1'b1;
      live_tick    = t;
      clear_slot(t);
      return;
    end
    if (t == live_tick) return;
    if (t < live_tick || gap >= TickW'(Window)) begin
      drop_all_buckets();
    end else begin
      for (int k = 1; k <= int'(gap); k++) clear_slot(live_tick + TickW'(k));
    end
    live_tick = t;
  endfunction

  function automatic tally_reply_t apply_request(input logic [ReqW-1:0]   kind,
                                                 input logic [TickW-1:0]  t,
                                                 input logic [CatW-1:0]   cat,
                                                 input logic [AmtW-1:0]   amt);
    tally_reply_t r;
    int           slot;
    r.total = '0;
    case (kind)
      ReqAdvance: move_to(t);
      ReqRecord: begin
        // a record on an unstarted block starts it at tick zero
        if (!live_started) move_to('0);
        if (int'(cat) < Categories) begin
          slot = int'(live_tick % TickW'(Window));
          bucket_sums[slot][cat] = sat_sum(bucket_sums[slot][cat], amt);
        end
      end
      ReqQuery: begin
        if (int'(cat) < Categories) begin
          for (int s = 0; s < Window; s++) r.total = sat_sum(r.total, bucket_sums[s][cat]);
        end
      end
      default: ;
    endcase
    r.tick    = live_tick;
    r.started = live_started;
    return r;
  endfunction

  function automatic void note_mismatch(input string field, input logic [63:0] want,
                                        input logic [63:0] seen);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxReports)
      $display("%0t tally mismatch on %s: expected %h, got %h", $realtime, field, want, seen);
  endfunction

  // Compare outgoing words first, then predict the incoming one
  always @(posedge clk_i or negedge rst_ni) begin : watch
    tally_reply_t seen;
    tally_reply_t want;
    if (!rst_ni) begin
      drop_all_buckets();
      live_tick    = '0;
      live_started = 1'b0;
      tally_results_q.delete();
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        seen.total   = m_axis_tdata_i[TotalW-1:0];
        seen.tick    = m_axis_tdata_i[TotalW+:TickW];
        seen.started = m_axis_tuser_i;
        if (tally_results_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MaxReports)
            $display("%0t tally word with none expected: total %h tick %h started %b",
                     $realtime, seen.total, seen.tick, seen.started);
        end else begin
          want = tally_results_q.pop_front();
          if (seen.total !== want.total) note_mismatch("window_total", want.total, seen.total);
          if (seen.tick !== want.tick) note_mismatch("current_tick", want.tick, seen.tick);
          if (seen.started !== want.started)
            note_mismatch("started", 64'(want.started), 64'(seen.started));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        tally_results_q.push_back(apply_request(s_axis_tuser_i,
                                                s_axis_tdata_i[TickW-1:0],
                                                s_axis_tdata_i[TickW+:CatW],
                                                s_axis_tdata_i[TickW+CatW+:AmtW]));
      pending_o <= tally_results_q.size();
    end
  end

endmodule

FILE: sim/windowed_saturating_tally_tb.sv
// ----------------------------------------------------------------------------
// windowed_saturating_tally_tb
// Drives advance, record and query requests into the tally: a directed run
// over the start-up, saturation, window-edge and jump cases, then random
// request streams in four idle/stall phases. The checker beside the block
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module windowed_saturating_tally_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wst_pkg::*;

  localparam int          IdleLimit    = 3000;  // cycles with no word moving
  localparam int          DrainCycles  = 100;   // longer than the slowest request
  localparam int          RandPerPhase = 285;
  localparam logic [63:0] Max64        = {64{1'b1}};

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;
  logic [ReqW-1:0]     s_axis_tuser_i  = ReqAdvance;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tuser_o;

  int          fail_cnt;
  int          pending_cnt;
  int          src_idle_pct  = 0;
  int          snk_stall_pct = 0;
  int          quiet_cycles  = 0;
  logic [63:0] gen_tick      = '0;  // last tick the stimulus advanced to

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  windowed_saturating_tally u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  wst_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tuser_i  (m_axis_tuser_o),
    .fail_cnt_o      (fail_cnt),
    .pending_o       (pending_cnt)
  );

  // Result side: random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Watchdog: give up when no word moves on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one request word and hold it until accepted; called at a clock edge
  task automatic send_req(input logic [ReqW-1:0] kind, input logic [TickW-1:0] tick,
                          input logic [CatW-1:0] cat, input logic [AmtW-1:0] amt);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(InDataW - TickW - CatW - AmtW){1'b0}}, amt, cat, tick};
    s_axis_tuser_i  <= kind;
    if (kind == ReqAdvance) gen_tick = tick;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Mostly short forward steps with records and queries between them;
  // some same-tick, backward, far and fully random ticks as noise
  task automatic random_request();
    int unsigned     pick;
    int unsigned     way;
    logic [63:0]     target;
    logic [63:0]     amt;
    logic [CatW-1:0] cat;
    pick   = $urandom_range(99);
    way    = $urandom_range(99);
    cat    = CatW'($urandom_range(7));
    amt    = {$urandom, $urandom};
    target = {$urandom, $urandom};
    if (pick < 40) begin
      if (way < 60)      target = gen_tick + 64'($urandom_range(1, 3));
      else if (way < 72) target = gen_tick + 64'($urandom_range(4, 20));
      else if (way < 80) target = gen_tick;
      else if (way < 88) target = gen_tick - 64'($urandom_range(1, 40));
      send_req(ReqAdvance, target, cat, amt);
    end else if (pick < 75) begin
      if (way < 60)      amt = 64'($urandom_range(1000));
      else if (way < 85) amt = {$urandom, $urandom};
      else               amt = Max64 - 64'($urandom_range(3));
      send_req(ReqRecord, target, cat, amt);
    end else begin
      send_req(ReqQuery, target, cat, amt);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // query before start, then a record that starts the block at tick zero
    send_req(ReqQuery,   64'd9, 3'd0, 64'd7);
    send_req(ReqRecord,  64'd44, 3'd7, 64'd5);
    send_req(ReqQuery,   '0, 3'd7, '0);
    // advance to the same tick, then a short step
    send_req(ReqAdvance, 64'd0, 3'd1, Max64);
    send_req(ReqAdvance, 64'd3, 3'd0, '0);
    // saturation inside one bucket
    send_req(ReqRecord,  '0, 3'd0, Max64);
    send_req(ReqRecord,  '0, 3'd0, 64'd1);
    send_req(ReqQuery,   '0, 3'd0, '0);
    // saturation of the sum across two buckets
    send_req(ReqAdvance, 64'd4, 3'd0, '0);
    send_req(ReqRecord,  '0, 3'd4, 64'h8000_0000_0000_0000);
    send_req(ReqAdvance, 64'd5, 3'd0, '0);
    send_req(ReqRecord,  '0, 3'd4, 64'h8000_0000_0000_0000);
    send_req(ReqQuery,   '0, 3'd4, '0);
    // widest step that stays inside the window, then one tick further
    send_req(ReqAdvance, 64'd20, 3'd0, '0);
    send_req(ReqQuery,   '0, 3'd4, '0);
    send_req(ReqAdvance, 64'd36, 3'd0, '0);
    send_req(ReqQuery,   '0, 3'd4, '0);
    // backward move, far jump to the top of the range, step onto the max tick
    send_req(ReqAdvance, 64'd10, 3'd0, '0);
    send_req(ReqAdvance, Max64 - 64'd15, 3'd0, '0);
    send_req(ReqRecord,  Max64, 3'd5, 64'hAAAA_AAAA_AAAA_AAAA);
    send_req(ReqAdvance, Max64, 3'd0, '0);
    send_req(ReqRecord,  '0, 3'd2, 64'h5555_5555_5555_5555);
    send_req(ReqQuery,   Max64, 3'd5, Max64);
    send_req(ReqAdvance, 64'd0, 3'd0, '0);
    send_req(ReqQuery,   '0, 3'd2, '0);

    // random streams: no idling, sender gaps, receiver stalls, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1:       begin src_idle_pct = 56; snk_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  snk_stall_pct = 56; end
        default: begin src_idle_pct = 37; snk_stall_pct = 37; end
      endcase
      repeat (RandPerPhase) random_request();
    end
    s_axis_tvalid_i <= 1'b0;

    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/wst_pkg.sv
rtl/wst_ram.sv
rtl/wst_dp.sv
rtl/wst_ctrl.sv
rtl/windowed_saturating_tally.sv
sim/wst_checker.sv
sim/windowed_saturating_tally_tb.sv
